// ===== rtl/cube_sphere_vertex_generator_core_macros.svh =====
// Assertion macros for the cube-sphere vertex generator.
// Included by RTL files that carry concurrent checks; no other dependencies.
`ifndef CUBE_SPHERE_VERTEX_GENERATOR_CORE_MACROS_SVH
`define CUBE_SPHERE_VERTEX_GENERATOR_CORE_MACROS_SVH
`ifndef SYNTH
// antecedent implies consequent in the same cycle
`define CSVG_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// antecedent implies consequent in the next cycle
`define CSVG_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define CSVG_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define CSVG_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== rtl/csvg_pkg.sv =====
// Shared constants, types and tables of the cube-sphere vertex generator.
// No dependencies; imported by every RTL module of the block.
package csvg_pkg;

  localparam int MAX_SUBDIVISION = 8;
  localparam int COORD_FRAC_BITS = 14;
  localparam int ANG_STEPS = 24;
  localparam int KW = $clog2(ANG_STEPS);
  localparam int XW = 36;               // CORDIC x/y width
  localparam int ZW = 34;               // binary angle width
  localparam int CW = 32;               // sin/cos and cross product width
  localparam int CORD_FRAC = 30;
  localparam int SQ_STEPS = 32;
  localparam int SQW = $clog2(SQ_STEPS);
  localparam int LW = 32;               // vector length width
  localparam int DIV_STEPS = COORD_FRAC_BITS + 1;
  localparam int DIVW = $clog2(DIV_STEPS);
  localparam int DW = LW + COORD_FRAC_BITS + 2;
  localparam int DLY = ANG_STEPS - DIV_STEPS;

  localparam logic signed [XW-1:0] CORDIC_X0 = XW'(652032874);
  localparam logic signed [ZW-1:0] ANG_QTR = ZW'(64'sd536870912);
  localparam logic signed [ZW-1:0] ANG_HALF = ZW'(64'sd2147483648);

  // pipeline stage map
  localparam int ST_MUL = ANG_STEPS + 1;
  localparam int ST_CRS = ST_MUL + 1;
  localparam int ST_SQR = ST_CRS + 1;
  localparam int ST_SUM = ST_SQR + 1;
  localparam int ST_PRE = ST_SUM + 1 + SQ_STEPS;
  localparam int ST_OUT = ST_PRE + ANG_STEPS + 1;
  localparam int CRS_N = ST_PRE - ST_CRS;

  localparam int TDI_W = 24;
  localparam int TDO_W = 88;

  typedef enum logic [2:0] {
    PC_ZERO = 3'd0,
    PC_PSIN = 3'd1,
    PC_NSIN = 3'd2,
    PC_PCOS = 3'd3,
    PC_NCOS = 3'd4
  } plane_code_e;

  typedef struct packed {
    logic       len_zero;
    logic [2:0] neg;        // sign of cx, cy, cz
    logic       th_zero;
    logic       ph_zero;
  } side_t;

  // arctangent of 2^-k in binary angle units
  function automatic logic signed [ZW-1:0] ang_step(input logic [KW-1:0] k);
    logic signed [ZW-1:0] t;
    case (k)
      5'd0:  t = ZW'(536870912);
      5'd1:  t = ZW'(316933406);
      5'd2:  t = ZW'(167458907);
      5'd3:  t = ZW'(85004756);
      5'd4:  t = ZW'(42667331);
      5'd5:  t = ZW'(21354465);
      5'd6:  t = ZW'(10679838);
      5'd7:  t = ZW'(5340245);
      5'd8:  t = ZW'(2670163);
      5'd9:  t = ZW'(1335087);
      5'd10: t = ZW'(667544);
      5'd11: t = ZW'(333772);
      5'd12: t = ZW'(166886);
      5'd13: t = ZW'(83443);
      5'd14: t = ZW'(41722);
      5'd15: t = ZW'(20861);
      5'd16: t = ZW'(10430);
      5'd17: t = ZW'(5215);
      5'd18: t = ZW'(2608);
      5'd19: t = ZW'(1304);
      5'd20: t = ZW'(652);
      5'd21: t = ZW'(326);
      5'd22: t = ZW'(163);
      5'd23: t = ZW'(81);
      default: t = '0;
    endcase
    return t;
  endfunction

  // plane normal component pattern per face; sel 0 uses column angle, 1 row angle
  function automatic plane_code_e plane_code(input logic [2:0] face, input logic sel,
                                             input logic [1:0] axis);
    plane_code_e c0, c1, c2, r;
    c0 = PC_ZERO; c1 = PC_ZERO; c2 = PC_ZERO;
    case ({face, sel})
      4'b000_0: begin c0 = PC_NSIN; c1 = PC_ZERO; c2 = PC_NCOS; end
      4'b000_1: begin c0 = PC_NSIN; c1 = PC_PCOS; c2 = PC_ZERO; end
      4'b001_0: begin c0 = PC_NCOS; c1 = PC_ZERO; c2 = PC_PSIN; end
      4'b001_1: begin c0 = PC_ZERO; c1 = PC_PCOS; c2 = PC_PSIN; end
      4'b010_0: begin c0 = PC_PSIN; c1 = PC_ZERO; c2 = PC_PCOS; end
      4'b010_1: begin c0 = PC_PSIN; c1 = PC_PCOS; c2 = PC_ZERO; end
      4'b011_0: begin c0 = PC_PCOS; c1 = PC_ZERO; c2 = PC_NSIN; end
      4'b011_1: begin c0 = PC_ZERO; c1 = PC_PCOS; c2 = PC_NSIN; end
      4'b100_0: begin c0 = PC_NCOS; c1 = PC_PSIN; c2 = PC_ZERO; end
      4'b100_1: begin c0 = PC_ZERO; c1 = PC_PSIN; c2 = PC_NCOS; end
      4'b101_0: begin c0 = PC_PCOS; c1 = PC_NSIN; c2 = PC_ZERO; end
      4'b101_1: begin c0 = PC_ZERO; c1 = PC_NSIN; c2 = PC_NCOS; end
      default: begin c0 = PC_ZERO; c1 = PC_ZERO; c2 = PC_ZERO; end
    endcase
    case (axis)
      2'd0: r = c0;
      2'd1: r = c1;
      2'd2: r = c2;
      default: r = PC_ZERO;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/cube_sphere_vertex_generator_core.sv =====
// Cube-sphere vertex generator: one grid point in, one unit vertex with UV out.
// Throughput one item per cycle while no result waits at the output.
// The pipe runs through the 24-cell sin/cos CORDIC row, the 32-cell square root row
// and the 24-cell arctangent row; the whole pipe holds while a result waits.
// Reset clears all valid bits and sets the subdivision level to 6.
// Depends on csvg_pkg, the three cell modules and the assertion macro header.
`include "cube_sphere_vertex_generator_core_macros.svh"
module cube_sphere_vertex_generator_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration: subdivision_level
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [3:0]                    cfg_data_i,
  // input items
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // face_number[2:0], row_number[11:3], column_number[20:12], zero pad
  input  logic [csvg_pkg::TDI_W-1:0]    s_axis_tdata,
  // result items
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // x_coord[15:0], y_coord[31:16], z_coord[47:32], tex_u[63:48], tex_v[80:64], zero pad
  output logic [csvg_pkg::TDO_W-1:0]    m_axis_tdata,
  // bad_position[0]
  output logic [0:0]                    m_axis_tuser
);
  import csvg_pkg::*;

  // control and configuration
  logic            adv;
  logic [3:0]      subdiv_q;
  logic            vld_q [0:ST_OUT];
  logic            bad_q [0:ST_OUT-1];

  // input decode
  logic [2:0]           in_face;
  logic [8:0]           in_row, in_col;
  logic [3:0]           s_eff;
  logic [9:0]           lim;
  logic                 in_bad;
  logic [38:0]          row_sh, col_sh;
  logic signed [ZW-1:0] a1_d, a2_d;

  // sin/cos rows
  logic [2:0]           face_q [0:ANG_STEPS];
  logic signed [XW-1:0] rx1 [0:ANG_STEPS];
  logic signed [XW-1:0] ry1 [0:ANG_STEPS];
  logic signed [ZW-1:0] rz1 [0:ANG_STEPS];
  logic signed [XW-1:0] rx2 [0:ANG_STEPS];
  logic signed [XW-1:0] ry2 [0:ANG_STEPS];
  logic signed [ZW-1:0] rz2 [0:ANG_STEPS];

  // cross product
  logic signed [CW-1:0] n1 [0:2];
  logic signed [CW-1:0] n2 [0:2];
  logic signed [63:0]   mul_q [0:5];
  logic signed [63:0]   dif [0:2];
  logic signed [CW-1:0] crs_d [0:2];
  logic signed [CW-1:0] crs_q [0:CRS_N-1][0:2];
  logic [63:0]          sq_q [0:2];
  logic [63:0]          sum3_q, sum2_q;

  // square roots
  logic [63:0] sv3 [0:SQ_STEPS];
  logic [63:0] sr3 [0:SQ_STEPS];
  logic [63:0] sv2 [0:SQ_STEPS];
  logic [63:0] sr2 [0:SQ_STEPS];

  // division and arctangent
  logic signed [CW-1:0] cf [0:2];
  logic [LW-1:0]        len, rlen;
  logic [CW-1:0]        cabs [0:2];
  logic [DW-1:0]        drem [0:2][0:DIV_STEPS];
  logic [DIV_STEPS-1:0] dq [0:2][0:DIV_STEPS];
  logic [LW-1:0]        dd [0:2][0:DIV_STEPS];
  logic [DIV_STEPS-1:0] cd_q [0:DLY-1][0:2];
  logic signed [XW-1:0] tx_in, ty_in, px_in, py_in;
  logic signed [XW-1:0] tx [0:ANG_STEPS];
  logic signed [XW-1:0] ty [0:ANG_STEPS];
  logic signed [ZW-1:0] tz [0:ANG_STEPS];
  logic signed [XW-1:0] px [0:ANG_STEPS];
  logic signed [XW-1:0] py [0:ANG_STEPS];
  logic signed [ZW-1:0] pz [0:ANG_STEPS];
  side_t                side_d;
  side_t                side_q [0:ANG_STEPS];

  // output stage
  side_t                sd;
  logic                 kill;
  logic [15:0]          crd [0:2];
  logic signed [ZW-1:0] th, ph;
  logic [31:0]          ub, phc;
  logic [32:0]          u_sum, v_sum;
  logic [TDO_W-1:0]     tdata_d, tdata_q;
  logic                 tuser_q;

  function automatic logic signed [CW-1:0] pick(input plane_code_e c,
                                                input logic signed [CW-1:0] s,
                                                input logic signed [CW-1:0] cv);
    logic signed [CW-1:0] r;
    unique case (c)
      PC_PSIN: r = s;
      PC_NSIN: r = -s;
      PC_PCOS: r = cv;
      PC_NCOS: r = -cv;
      default: r = '0;
    endcase
    return r;
  endfunction

  // whole pipe advances unless a result is held at the output
  assign adv           = !vld_q[ST_OUT] || m_axis_tready;
  assign s_axis_tready = adv;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      subdiv_q <= 4'd6;
    end else if (cfg_valid_i) begin
      subdiv_q <= cfg_data_i;
    end
  end

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= ST_OUT; i++) vld_q[i] <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= s_axis_tvalid;
      for (int i = 1; i <= ST_OUT; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  // input decode: range check and angles
  assign in_face = s_axis_tdata[2:0];
  assign in_row  = s_axis_tdata[11:3];
  assign in_col  = s_axis_tdata[20:12];
  assign s_eff   = (subdiv_q > 4'(MAX_SUBDIVISION)) ? 4'(MAX_SUBDIVISION) : subdiv_q;
  assign lim     = 10'd1 << s_eff;
  assign in_bad  = (in_face > 3'd5) || ({1'b0, in_row} > lim) || ({1'b0, in_col} > lim);
  assign row_sh  = {in_row, 30'b0} >> s_eff;
  assign col_sh  = {in_col, 30'b0} >> s_eff;
  assign a2_d    = ANG_QTR - ZW'(row_sh);
  assign a1_d    = ZW'(col_sh) - ANG_QTR;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      bad_q[0]  <= in_bad;
      face_q[0] <= in_face;
      rz1[0]    <= a1_d;
      rz2[0]    <= a2_d;
      for (int i = 1; i < ST_OUT; i++) bad_q[i] <= bad_q[i-1];
      for (int i = 1; i <= ANG_STEPS; i++) face_q[i] <= face_q[i-1];
    end
  end

  assign rx1[0] = CORDIC_X0;
  assign ry1[0] = '0;
  assign rx2[0] = CORDIC_X0;
  assign ry2[0] = '0;

  // sin/cos of both angles
  for (genvar k = 0; k < ANG_STEPS; k++) begin : g_rot
    csvg_cordic_cell u_rot1 (
      .clk_i (clk_i), .en_i (adv), .vec_i (1'b0), .k_i (KW'(k)),
      .x_i (rx1[k]), .y_i (ry1[k]), .z_i (rz1[k]),
      .x_o (rx1[k+1]), .y_o (ry1[k+1]), .z_o (rz1[k+1])
    );
    csvg_cordic_cell u_rot2 (
      .clk_i (clk_i), .en_i (adv), .vec_i (1'b0), .k_i (KW'(k)),
      .x_i (rx2[k]), .y_i (ry2[k]), .z_i (rz2[k]),
      .x_o (rx2[k+1]), .y_o (ry2[k+1]), .z_o (rz2[k+1])
    );
  end

  // plane normals and cross product terms
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      n1[j] = pick(plane_code(face_q[ANG_STEPS], 1'b0, 2'(j)),
                   CW'(ry1[ANG_STEPS]), CW'(rx1[ANG_STEPS]));
      n2[j] = pick(plane_code(face_q[ANG_STEPS], 1'b1, 2'(j)),
                   CW'(ry2[ANG_STEPS]), CW'(rx2[ANG_STEPS]));
    end
  end

  always_comb begin
    dif[0] = mul_q[0] - mul_q[1];
    dif[1] = mul_q[2] - mul_q[3];
    dif[2] = mul_q[4] - mul_q[5];
    for (int j = 0; j < 3; j++) crs_d[j] = dif[j][CORD_FRAC+CW-1:CORD_FRAC];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mul_q[0] <= 64'(n1[1] * n2[2]);
      mul_q[1] <= 64'(n1[2] * n2[1]);
      mul_q[2] <= 64'(n1[2] * n2[0]);
      mul_q[3] <= 64'(n1[0] * n2[2]);
      mul_q[4] <= 64'(n1[0] * n2[1]);
      mul_q[5] <= 64'(n1[1] * n2[0]);
      for (int j = 0; j < 3; j++) begin
        crs_q[0][j] <= crs_d[j];
        sq_q[j]     <= 64'(crs_q[0][j] * crs_q[0][j]);
      end
      for (int i = 1; i < CRS_N; i++) crs_q[i] <= crs_q[i-1];
      sum3_q <= sq_q[0] + sq_q[1] + sq_q[2];
      sum2_q <= sq_q[0] + sq_q[2];
    end
  end

  // square roots of full length and of horizontal length
  assign sv3[0] = sum3_q;
  assign sr3[0] = '0;
  assign sv2[0] = sum2_q;
  assign sr2[0] = '0;

  for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
    csvg_sqrt_cell u_sq3 (
      .clk_i (clk_i), .en_i (adv), .i_i (SQW'(SQ_STEPS-1-j)),
      .v_i (sv3[j]), .r_i (sr3[j]), .v_o (sv3[j+1]), .r_o (sr3[j+1])
    );
    csvg_sqrt_cell u_sq2 (
      .clk_i (clk_i), .en_i (adv), .i_i (SQW'(SQ_STEPS-1-j)),
      .v_i (sv2[j]), .r_i (sr2[j]), .v_o (sv2[j+1]), .r_o (sr2[j+1])
    );
  end

  // set up division and arctangent operands
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      cf[j]   = crs_q[CRS_N-1][j];
      cabs[j] = cf[j][CW-1] ? CW'(-cf[j]) : CW'(cf[j]);
    end
    len  = sr3[SQ_STEPS][LW-1:0];
    rlen = sr2[SQ_STEPS][LW-1:0];
    tx_in = XW'(cf[0]);
    ty_in = -XW'(cf[2]);
    px_in = -XW'(cf[1]);
    py_in = XW'({1'b0, rlen});
    side_d.len_zero = (len == '0);
    side_d.neg      = {cf[2][CW-1], cf[1][CW-1], cf[0][CW-1]};
    side_d.th_zero  = (tx_in == '0) && (ty_in == '0);
    side_d.ph_zero  = (px_in == '0) && (py_in == '0);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int j = 0; j < 3; j++) begin
        drem[j][0] <= (DW'(cabs[j]) << COORD_FRAC_BITS) + DW'(len >> 1);
        dq[j][0]   <= '0;
        dd[j][0]   <= len;
      end
      // fold left half plane onto the right
      tx[0] <= tx_in[XW-1] ? -tx_in : tx_in;
      ty[0] <= tx_in[XW-1] ? -ty_in : ty_in;
      tz[0] <= tx_in[XW-1] ? ANG_HALF : '0;
      px[0] <= px_in[XW-1] ? -px_in : px_in;
      py[0] <= px_in[XW-1] ? -py_in : py_in;
      pz[0] <= px_in[XW-1] ? ANG_HALF : '0;
      side_q[0] <= side_d;
      for (int i = 1; i <= ANG_STEPS; i++) side_q[i] <= side_q[i-1];
      for (int j = 0; j < 3; j++) cd_q[0][j] <= dq[j][DIV_STEPS];
      for (int i = 1; i < DLY; i++) cd_q[i] <= cd_q[i-1];
    end
  end

  // coordinate division rows, one per axis
  for (genvar l = 0; l < 3; l++) begin : g_lane
    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
      csvg_div_cell u_div (
        .clk_i (clk_i), .en_i (adv), .i_i (DIVW'(DIV_STEPS-1-j)),
        .rem_i (drem[l][j]), .q_i (dq[l][j]), .d_i (dd[l][j]),
        .rem_o (drem[l][j+1]), .q_o (dq[l][j+1]), .d_o (dd[l][j+1])
      );
    end
  end

  // longitude and latitude arctangents
  for (genvar k = 0; k < ANG_STEPS; k++) begin : g_vec
    csvg_cordic_cell u_vec_th (
      .clk_i (clk_i), .en_i (adv), .vec_i (1'b1), .k_i (KW'(k)),
      .x_i (tx[k]), .y_i (ty[k]), .z_i (tz[k]),
      .x_o (tx[k+1]), .y_o (ty[k+1]), .z_o (tz[k+1])
    );
    csvg_cordic_cell u_vec_ph (
      .clk_i (clk_i), .en_i (adv), .vec_i (1'b1), .k_i (KW'(k)),
      .x_i (px[k]), .y_i (py[k]), .z_i (pz[k]),
      .x_o (px[k+1]), .y_o (py[k+1]), .z_o (pz[k+1])
    );
  end

  // result assembly
  always_comb begin
    sd   = side_q[ANG_STEPS];
    kill = bad_q[ST_OUT-1] || sd.len_zero;
    for (int j = 0; j < 3; j++) begin
      crd[j] = sd.neg[j] ? 16'(-{1'b0, cd_q[DLY-1][j]}) : 16'(cd_q[DLY-1][j]);
    end
    th    = sd.th_zero ? '0 : tz[ANG_STEPS];
    ph    = sd.ph_zero ? '0 : pz[ANG_STEPS];
    ub    = th[31:0] ^ 32'h8000_0000;
    u_sum = {1'b0, ub} + 33'h0_0000_8000;
    if (ph[ZW-1]) begin
      phc = '0;
    end else if (ph > ANG_HALF) begin
      phc = 32'h8000_0000;
    end else begin
      phc = ph[31:0];
    end
    v_sum   = {1'b0, phc} + 33'h0_0000_4000;
    tdata_d = '0;
    if (!kill) begin
      tdata_d[15:0]  = crd[0];
      tdata_d[31:16] = crd[1];
      tdata_d[47:32] = crd[2];
      tdata_d[63:48] = u_sum[31:16];
      tdata_d[80:64] = v_sum[31:15];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      tdata_q <= tdata_d;
      tuser_q <= bad_q[ST_OUT-1];
    end
  end

  assign m_axis_tvalid   = vld_q[ST_OUT];
  assign m_axis_tdata    = tdata_q;
  assign m_axis_tuser[0] = tuser_q;

  `CSVG_ASSERT_IMP(a_bad_zero, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == '0)
  `CSVG_ASSERT_IMP(a_stall_holds_in, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, !s_axis_tready)
  `CSVG_ASSERT_NXT(a_accept_enters, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, vld_q[0])
  `CSVG_ASSERT_IMP(a_texv_range, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[80:64] <= 17'd65536)

endmodule

// ===== rtl/csvg_cordic_cell.sv =====
// One CORDIC micro-rotation with its output register.
// Depends on csvg_pkg; rotation or vectoring selected by vec_i.
module csvg_cordic_cell (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic                           vec_i,
  input  logic [csvg_pkg::KW-1:0]        k_i,
  input  logic signed [csvg_pkg::XW-1:0] x_i,
  input  logic signed [csvg_pkg::XW-1:0] y_i,
  input  logic signed [csvg_pkg::ZW-1:0] z_i,
  output logic signed [csvg_pkg::XW-1:0] x_o,
  output logic signed [csvg_pkg::XW-1:0] y_o,
  output logic signed [csvg_pkg::ZW-1:0] z_o
);
  import csvg_pkg::*;

  logic signed [XW-1:0] xs, ys, x_d, y_d, x_q, y_q;
  logic signed [ZW-1:0] t, z_d, z_q;
  logic                 pos;

  // rotation drives z toward zero, vectoring drives y toward zero
  assign xs  = x_i >>> k_i;
  assign ys  = y_i >>> k_i;
  assign t   = ang_step(k_i);
  assign pos = vec_i ? y_i[XW-1] : !z_i[ZW-1];

  always_comb begin
    if (pos) begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      z_d = z_i - t;
    end else begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      z_d = z_i + t;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;

endmodule

// ===== rtl/csvg_sqrt_cell.sv =====
// One bit-pair step of an integer square root, registered.
// Depends on csvg_pkg for the step index width.
module csvg_sqrt_cell (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [csvg_pkg::SQW-1:0] i_i,
  input  logic [63:0]              v_i,
  input  logic [63:0]              r_i,
  output logic [63:0]              v_o,
  output logic [63:0]              r_o
);
  import csvg_pkg::*;

  logic [63:0] b, trial, v_d, r_d, v_q, r_q;

  // trial subtract of root plus the current bit
  assign b     = 64'd1 << {i_i, 1'b0};
  assign trial = r_i + b;

  always_comb begin
    if (v_i >= trial) begin
      v_d = v_i - trial;
      r_d = (r_i >> 1) + b;
    end else begin
      v_d = v_i;
      r_d = r_i >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v_q <= v_d;
      r_q <= r_d;
    end
  end

  assign v_o = v_q;
  assign r_o = r_q;

endmodule

// ===== rtl/csvg_div_cell.sv =====
// One quotient bit of a restoring division, registered.
// Depends on csvg_pkg for the remainder and quotient widths.
module csvg_div_cell (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic [csvg_pkg::DIVW-1:0]      i_i,
  input  logic [csvg_pkg::DW-1:0]        rem_i,
  input  logic [csvg_pkg::DIV_STEPS-1:0] q_i,
  input  logic [csvg_pkg::LW-1:0]        d_i,
  output logic [csvg_pkg::DW-1:0]        rem_o,
  output logic [csvg_pkg::DIV_STEPS-1:0] q_o,
  output logic [csvg_pkg::LW-1:0]        d_o
);
  import csvg_pkg::*;

  logic [DW-1:0]        ds, rem_d, rem_q;
  logic [DIV_STEPS-1:0] q_d, q_q;
  logic [LW-1:0]        d_q;

  // divisor aligned to this quotient bit
  assign ds = DW'(d_i) << i_i;

  always_comb begin
    if (rem_i >= ds) begin
      rem_d = rem_i - ds;
      q_d   = q_i | (DIV_STEPS'(1) << i_i);
    end else begin
      rem_d = rem_i;
      q_d   = q_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      q_q   <= q_d;
      d_q   <= d_i;
    end
  end

  assign rem_o = rem_q;
  assign q_o   = q_q;
  assign d_o   = d_q;

endmodule

// ===== sim/tb_top.sv =====
// Testbench for the cube-sphere vertex generator core: predicts each vertex and UV
// with a bit-exact fixed-point model and checks the result stream. Depends on csvg_pkg.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import csvg_pkg::*;

  localparam string PASS_MSG = "cube_sphere_vertex_generator_core test passed";
  localparam string FAIL_MSG = "cube_sphere_vertex_generator_core test failed";
  localparam int PIPE_LAT = 87;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
    logic [15:0] u;
    logic [16:0] v;
    logic        bad;
  } vertex_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [3:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [TDI_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [TDO_W-1:0] m_axis_tdata;
  logic [0:0] m_axis_tuser;

  cube_sphere_vertex_generator_core dut (.*);

  always #5 clk_i = ~clk_i;

  vertex_t vertex_q[$];
  int unsigned mismatches = 0;
  int unsigned level = 6;
  bit calm = 1'b0;     // no idling on either side while set

  // arctangent table, binary angle units
  longint ang_tab[24] = '{536870912, 316933406, 167458907, 85004756, 42667331,
    21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};

  function automatic longint isqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic void rotate(input longint ang, output longint c, output longint s);
    longint x, y, nx, ny;
    x = 652032874;
    y = 0;
    for (int k = 0; k < 24; k++) begin
      if (ang >= 0) begin
        nx = x - (y >>> k); ny = y + (x >>> k); ang -= ang_tab[k];
      end else begin
        nx = x + (y >>> k); ny = y - (x >>> k); ang += ang_tab[k];
      end
      x = nx; y = ny;
    end
    c = x; s = y;
  endfunction

  function automatic longint heading(longint x, longint y);
    longint a, nx, ny;
    a = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      x = -x; y = -y; a = 64'sd2147483648;
    end
    for (int k = 0; k < 24; k++) begin
      if (y >= 0) begin
        nx = x + (y >>> k); ny = y - (x >>> k); a += ang_tab[k];
      end else begin
        nx = x - (y >>> k); ny = y + (x >>> k); a -= ang_tab[k];
      end
      x = nx; y = ny;
    end
    return a;
  endfunction

  function automatic longint pick(plane_code_e pc, longint s, longint c);
    case (pc)
      PC_PSIN: return s;
      PC_NSIN: return -s;
      PC_PCOS: return c;
      PC_NCOS: return -c;
      default: return 0;
    endcase
  endfunction

  function automatic logic [15:0] unit_coord(longint c, longint len);
    longint m, q;
    m = (c < 0) ? -c : c;
    q = ((m <<< COORD_FRAC_BITS) + (len >>> 1)) / len;
    if (c < 0) q = -q;
    return q[15:0];
  endfunction

  // expected vertex for one grid point at the current level
  function automatic vertex_t predict_vertex(logic [2:0] face, logic [8:0] row,
                                             logic [8:0] col);
    vertex_t e;
    int unsigned s;
    longint a1, a2, c1, s1, c2, s2, cx, cy, cz, len, r, th, ph;
    longint n1[3], n2[3];
    longint unsigned ub;
    e = '0;
    s = (level > MAX_SUBDIVISION) ? MAX_SUBDIVISION : level;
    if (face > 5 || row > (1 << s) || col > (1 << s)) begin
      e.bad = 1'b1;
      return e;
    end
    a2 = 536870912 - ((longint'(row) << 30) >> s);
    a1 = -536870912 + ((longint'(col) << 30) >> s);
    rotate(a1, c1, s1);
    rotate(a2, c2, s2);
    for (int j = 0; j < 3; j++) begin
      n1[j] = pick(plane_code(face, 1'b0, j[1:0]), s1, c1);
      n2[j] = pick(plane_code(face, 1'b1, j[1:0]), s2, c2);
    end
    cx = (n1[1] * n2[2] - n1[2] * n2[1]) >>> 30;
    cy = (n1[2] * n2[0] - n1[0] * n2[2]) >>> 30;
    cz = (n1[0] * n2[1] - n1[1] * n2[0]) >>> 30;
    len = isqrt(cx * cx + cy * cy + cz * cz);
    if (len == 0) return e;
    e.x = unit_coord(cx, len);
    e.y = unit_coord(cy, len);
    e.z = unit_coord(cz, len);
    th = heading(cx, -cz);
    ub = longint'(th + 64'sd2147483648) & 64'hFFFF_FFFF;
    e.u = 16'((ub + 64'h8000) >> 16);
    r = isqrt(cx * cx + cz * cz);
    ph = heading(-cy, r);
    if (ph < 0) ph = 0;
    if (ph > 64'sd2147483648) ph = 64'sd2147483648;
    e.v = 17'((ph + 64'h4000) >> 15);
    return e;
  endfunction

  // valid stays high between back-to-back items and drops only while idling
  task automatic send_point(input logic [2:0] face, input logic [8:0] row,
                            input logic [8:0] col);
    while (!calm && $urandom_range(99) < 34) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tdata <= {3'b0, col, row, face};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    vertex_q = {vertex_q, predict_vertex(face, row, col)};
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (vertex_q.size() != 0) @(negedge clk_i);
    repeat (PIPE_LAT + 10) @(negedge clk_i);
  endtask

  task automatic set_level(input int unsigned lv);
    drain();
    cfg_data_i <= lv[3:0];
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    level = lv;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // result checker and receiver idling
  always @(posedge clk_i) begin
    vertex_t got, want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tdata[47:32],
             m_axis_tdata[63:48], m_axis_tdata[80:64], m_axis_tuser[0]};
      if (vertex_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = vertex_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp x=%h y=%h z=%h u=%h v=%h bad=%b got x=%h y=%h z=%h u=%h v=%h bad=%b",
                     want.x, want.y, want.z, want.u, want.v, want.bad,
                     got.x, got.y, got.z, got.u, got.v, got.bad);
        end
      end
    end
  end

  always @(negedge clk_i) m_axis_tready <= calm || ($urandom_range(99) >= 34);

  // corners and center of every face, and out-of-range positions
  task automatic test_directed();
    set_level(0);
    for (int f = 0; f < 6; f++) begin
      send_point(3'(f), 0, 0);
      send_point(3'(f), 1, 1);
    end
    set_level(15);
    for (int f = 0; f < 6; f++) send_point(3'(f), 128, 128);
    send_point(0, 256, 256);
    send_point(1, 257, 0);
    send_point(2, 0, 511);
    send_point(6, 0, 0);
    send_point(7, 3, 3);
    set_level(1);
    send_point(4, 1, 1);
    send_point(5, 2, 2);
  endtask

  // random grid points, mostly in range, at several levels
  task automatic test_random();
    int unsigned lim;
    for (int ph = 0; ph < 6; ph++) begin
      set_level(ph == 0 ? 8 : $urandom_range(15));
      calm = (ph == 2);
      lim = 1 << ((level > 8) ? 8 : level);
      for (int i = 0; i < 240; i++) begin
        if ($urandom_range(9) == 0)
          send_point(3'($urandom_range(7)), 9'($urandom_range(511)),
                     9'($urandom_range(511)));
        else
          send_point(3'($urandom_range(5)), 9'($urandom_range(lim)),
                     9'($urandom_range(lim)));
      end
      calm = 1'b0;
    end
  endtask

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random();
    drain();
    if (mismatches == 0 && vertex_q.size() == 0) $display(PASS_MSG);
    else $display(FAIL_MSG);
    $finish;
  end

  initial begin
    #5ms;
    $display(FAIL_MSG);
    $finish;
  end
endmodule
